>>> rtl/core/sclu_pkg.sv
// Shared types, codes and helpers for the source line classifier.
`timescale 1ns / 1ps
package sclu_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int SHOW_WIDTH  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [SHOW_WIDTH-1:0]  show_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_END   = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_BLANK   = 2'd0,
		CLS_COMMENT = 2'd1,
		CLS_CODE    = 2'd2,
		CLS_NONE    = 2'd3
	} line_class_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_MARKER     = 3'd0,
		REG_LINE_MARKER_LEN = 3'd1,
		REG_BLOCK_ENABLE    = 3'd2,
		REG_BLOCK_OPEN      = 3'd3,
		REG_BLOCK_CLOSE     = 3'd4
	} reg_index_t;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] RST_LINE_MARKER = 16'd12079;
	localparam logic [1:0]  RST_MARKER_LEN  = 2'd2;
	localparam logic [15:0] RST_BLOCK_OPEN  = 16'd12074;
	localparam logic [15:0] RST_BLOCK_CLOSE = 16'd10799;

	typedef struct packed {
		logic [15:0] line_marker;
		logic [1:0]  line_marker_len;
		logic        block_enable;
		logic [15:0] block_open;
		logic [15:0] block_close;
	} cfg_t;

	typedef struct packed {
		logic inside_block;
		logic in_leading_space;
		logic first_token_seen;
		logic line_has_text;
		logic line_is_remark;
	} line_state_t;

	// line and block state at the start of a file
	localparam line_state_t LINE_CLEAR = '{inside_block: 1'b0, in_leading_space: 1'b1,
		first_token_seen: 1'b0, line_has_text: 1'b0, line_is_remark: 1'b0};

	typedef struct packed {
		line_class_t line_class;
		logic        file_done;
		show_t       blank_count;
		show_t       comment_count;
		show_t       code_count;
		show_t       file_count;
	} result_t;

	function automatic count_t bump(input count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
	endfunction

	function automatic show_t show_count(input count_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? {SHOW_WIDTH{1'b1}} : w[SHOW_WIDTH-1:0];
	endfunction

endpackage

>>> rtl/core/sclu_judge.sv
// Judges one held byte against its lookahead and updates the line state.
`timescale 1ns / 1ps
module sclu_judge (
	input  sclu_pkg::cfg_t        cfg,
	input  sclu_pkg::line_state_t st,
	input  logic [7:0]            c,
	input  logic [7:0]            nx,
	input  logic                  nx_ok,
	output sclu_pkg::line_state_t st_next
);

	logic close_hit, open_hit, line_hit, is_space;

	always_comb begin
		close_hit = cfg.block_enable && nx_ok && c == cfg.block_close[15:8]
			&& nx == cfg.block_close[7:0];
		open_hit  = cfg.block_enable && nx_ok && c == cfg.block_open[15:8]
			&& nx == cfg.block_open[7:0];
		case (cfg.line_marker_len)
			2'd0:    line_hit = 1'b0;
			2'd1:    line_hit = (c == cfg.line_marker[15:8]);
			default: line_hit = nx_ok && c == cfg.line_marker[15:8]
				&& nx == cfg.line_marker[7:0];
		endcase
		is_space = (c == sclu_pkg::CH_SPACE) || (c == sclu_pkg::CH_TAB)
			|| (c == sclu_pkg::CH_CR);
	end

	always_comb begin
		st_next = st;
		if (!(st.in_leading_space && is_space)) begin
			if (st.in_leading_space) begin
				st_next.in_leading_space = 1'b0;
				st_next.line_has_text    = 1'b1;
			end
			if (!st.first_token_seen) begin
				st_next.first_token_seen = 1'b1;
				if (st.inside_block) begin
					st_next.line_is_remark = 1'b1;
					if (close_hit)
						st_next.inside_block = 1'b0;
				end else if (line_hit) begin
					st_next.line_is_remark = 1'b1;
				end else if (open_hit) begin
					st_next.line_is_remark = 1'b1;
					st_next.inside_block   = 1'b1;
				end
			end else if (st.inside_block && close_hit) begin
				st_next.inside_block = 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/sclu_out_buf.sv
// Two-entry result buffer: output register with a skid stage behind it.
`timescale 1ns / 1ps
module sclu_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sclu_pkg::result_t push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output sclu_pkg::result_t out_data
);

	sclu_pkg::result_t skid_q;
	logic              skid_valid_q;
	logic              pop;

	assign pop   = out_valid && out_ready;
	assign space = !skid_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_data <= skid_q;
				if (push)
					skid_q <= push_data;
				else
					skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid || pop) begin
				out_data  <= push_data;
				out_valid <= 1'b1;
			end else begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid <= 1'b0;
		end
	end

endmodule

>>> rtl/core/source_line_classifier_unit.sv
// Top level of the source line classifier.
`timescale 1ns / 1ps
// Takes a file as a stream of requests (start, one byte each, end) and sorts
// every line into blank, comment or code, with saturating running totals.
// One request is taken per cycle: a request is registered, judged in the
// following cycle against the byte held back from the one before, and its
// result (on a newline or end of file) lands in a two-entry output buffer.
// A request passes the input register and then the output register; input
// stalls only when both entries are full and unpopped and the request has a result.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
module source_line_classifier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sclu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sclu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      op,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      line_class,
	output logic                            file_done,
	output logic [31:0]                     blank_count,
	output logic [31:0]                     comment_count,
	output logic [31:0]                     code_count,
	output logic [31:0]                     file_count
);

	sclu_pkg::cfg_t        cfg_q;
	sclu_pkg::line_state_t st_q, st_judged, st_j, st_new;
	sclu_pkg::op_t         op_s1;
	logic [7:0]            byte_s1;
	logic                  valid_s1;
	logic [7:0]            pending_byte_q;
	logic                  pending_valid_q;
	sclu_pkg::count_t      blank_q, remark_q, code_q, file_q;
	sclu_pkg::count_t      blank_n, remark_n, code_n;
	sclu_pkg::line_class_t cls;
	sclu_pkg::result_t     res, out_data;
	logic                  is_nl, has_res, space, s1_adv;
	logic [7:0]            nx;
	logic                  nx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_marker     <= sclu_pkg::RST_LINE_MARKER;
			cfg_q.line_marker_len <= sclu_pkg::RST_MARKER_LEN;
			cfg_q.block_enable    <= 1'b1;
			cfg_q.block_open      <= sclu_pkg::RST_BLOCK_OPEN;
			cfg_q.block_close     <= sclu_pkg::RST_BLOCK_CLOSE;
		end else if (cfg_we) begin
			case (sclu_pkg::reg_index_t'(cfg_index))
				sclu_pkg::REG_LINE_MARKER:     cfg_q.line_marker     <= cfg_data;
				sclu_pkg::REG_LINE_MARKER_LEN: cfg_q.line_marker_len <= cfg_data[1:0];
				sclu_pkg::REG_BLOCK_ENABLE:    cfg_q.block_enable    <= cfg_data[0];
				sclu_pkg::REG_BLOCK_OPEN:      cfg_q.block_open      <= cfg_data;
				sclu_pkg::REG_BLOCK_CLOSE:     cfg_q.block_close     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_nl   = (byte_s1 == sclu_pkg::CH_NL);
	assign has_res = (op_s1 == sclu_pkg::OP_END) || (op_s1 == sclu_pkg::OP_DATA && is_nl);
	assign s1_adv  = valid_s1 && (!has_res || space);
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			op_s1    <= sclu_pkg::op_t'(op);
			byte_s1  <= data_byte;
		end
	end

	assign nx    = (op_s1 == sclu_pkg::OP_DATA) ? byte_s1 : 8'h00;
	assign nx_ok = (op_s1 == sclu_pkg::OP_DATA);

	sclu_judge u_judge (
		.cfg     (cfg_q),
		.st      (st_q),
		.c       (pending_byte_q),
		.nx      (nx),
		.nx_ok   (nx_ok),
		.st_next (st_judged)
	);

	assign st_j = pending_valid_q ? st_judged : st_q;

	always_comb begin
		cls      = sclu_pkg::CLS_NONE;
		blank_n  = blank_q;
		remark_n = remark_q;
		code_n   = code_q;
		if (!st_j.line_has_text) begin
			if (op_s1 == sclu_pkg::OP_DATA) begin
				cls     = sclu_pkg::CLS_BLANK;
				blank_n = sclu_pkg::bump(blank_q);
			end
		end else if (st_j.line_is_remark) begin
			cls      = sclu_pkg::CLS_COMMENT;
			remark_n = sclu_pkg::bump(remark_q);
		end else begin
			cls    = sclu_pkg::CLS_CODE;
			code_n = sclu_pkg::bump(code_q);
		end
		res.line_class    = cls;
		res.file_done     = (op_s1 == sclu_pkg::OP_END);
		res.blank_count   = sclu_pkg::show_count(blank_n);
		res.comment_count = sclu_pkg::show_count(remark_n);
		res.code_count    = sclu_pkg::show_count(code_n);
		res.file_count    = sclu_pkg::show_count(file_q);
	end

	// fresh line; block state kept unless the file closes
	always_comb begin
		st_new                  = st_j;
		st_new.in_leading_space = 1'b1;
		st_new.first_token_seen = 1'b0;
		st_new.line_has_text    = 1'b0;
		st_new.line_is_remark   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= '{inside_block: 1'b0, in_leading_space: 1'b1,
				first_token_seen: 1'b0, line_has_text: 1'b0, line_is_remark: 1'b0};
			pending_byte_q  <= 8'h00;
			pending_valid_q <= 1'b0;
			blank_q         <= '0;
			remark_q        <= '0;
			code_q          <= '0;
			file_q          <= '0;
		end else if (s1_adv) begin
			case (op_s1)
				sclu_pkg::OP_START: begin
					file_q          <= sclu_pkg::bump(file_q);
					st_q            <= sclu_pkg::LINE_CLEAR;
					pending_byte_q  <= 8'h00;
					pending_valid_q <= 1'b0;
				end
				sclu_pkg::OP_DATA: begin
					if (is_nl) begin
						st_q            <= st_new;
						pending_valid_q <= 1'b0;
						blank_q         <= blank_n;
						remark_q        <= remark_n;
						code_q          <= code_n;
					end else begin
						st_q            <= st_j;
						pending_byte_q  <= byte_s1;
						pending_valid_q <= 1'b1;
					end
				end
				sclu_pkg::OP_END: begin
					st_q            <= sclu_pkg::LINE_CLEAR;
					pending_byte_q  <= 8'h00;
					pending_valid_q <= 1'b0;
					remark_q        <= remark_n;
					code_q          <= code_n;
				end
				default: ;
			endcase
		end
	end

	sclu_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_adv && has_res),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign line_class    = out_data.line_class;
	assign file_done     = out_data.file_done;
	assign blank_count   = out_data.blank_count;
	assign comment_count = out_data.comment_count;
	assign code_count    = out_data.code_count;
	assign file_count    = out_data.file_count;

endmodule

>>> rtl/core/sclu_checker.sv
// Port-level checks for the source line classifier, bound to the top level.
`timescale 1ns / 1ps
module sclu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  line_class,
	input logic        file_done,
	input logic [31:0] blank_count,
	input logic [31:0] comment_count,
	input logic [31:0] code_count,
	input logic [31:0] file_count
);

	// a stalled result holds its class, end flag and blank and file totals
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_class)
			&& $stable(file_done) && $stable(blank_count) && $stable(file_count))
		else $error("stalled result changed");

	// an empty last line is only reported at end of file
	a_none_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_class == sclu_pkg::CLS_NONE |-> file_done)
		else $error("no-line class outside end of file");

	// totals never fall from one result to the next
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |-> blank_count >= $past(blank_count)
			&& comment_count >= $past(comment_count) && code_count >= $past(code_count)
			&& file_count >= $past(file_count))
		else $error("running total decreased");

	// blank total moves only on a blank line
	a_blank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && line_class != sclu_pkg::CLS_BLANK
			|-> blank_count == $past(blank_count))
		else $error("blank total moved on a non-blank line");

endmodule

bind source_line_classifier_unit sclu_checker u_sclu_checker (.*);
